### hdl/led_blink_pattern_sequencer_defines.svh
// Assertion macros for the blink sequencer. Clock and reset are the
// module's own clock and reset signals.
`ifndef LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// cond must hold at every edge out of reset
`define LBPS_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// trigger at one edge implies cons at the next edge
`define LBPS_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);
`else
`define LBPS_ASSERT(label, cond, msg)
`define LBPS_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

### hdl/lbps_pkg.sv
package lbps_pkg;

   localparam int PATTERN_COUNT     = 16;
   localparam int SLOTS_PER_PATTERN = 16;

   localparam int PAT_W       = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
   localparam int SLOT_W      = $clog2(SLOTS_PER_PATTERN);
   localparam int SLOT_ADDR_W = $clog2(PATTERN_COUNT * SLOTS_PER_PATTERN);

   localparam int NUM_W   = 5;
   localparam int IDX_W   = 4;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 12;
   localparam int ROUND_W = 8;
   localparam int PRIO_W  = 2;
   localparam int HDR_W   = 12;

   localparam logic [CNT_W-1:0]  GAP_TICKS  = CNT_W'(5);
   localparam logic [CNT_W-1:0]  TICK_SCALE = CNT_W'(10);
   localparam logic [PRIO_W-1:0] PRIO_SAVE  = PRIO_W'(1);
   localparam logic [PRIO_W-1:0] PRIO_LOCK  = PRIO_W'(2);

   typedef enum logic [1:0] {
      MODE_TICK,
      MODE_START,
      MODE_WR_HDR,
      MODE_WR_SLOT
   } mode_type;

   typedef struct packed {
      logic                green;
      logic                red;
      logic [ROUND_W-1:0]  rep_total;
      logic [PRIO_W-1:0]   prio;
   } hdr_type;

   typedef struct packed {
      logic             red;
      logic             green;
      logic [NUM_W-1:0] running;
      logic             saved;
   } rsp_type;

   function automatic logic num_ok(logic [NUM_W-1:0] num);
      return (num != '0) && ({2'b00, num} <= 7'(PATTERN_COUNT));
   endfunction

   function automatic logic idx_ok(logic [IDX_W-1:0] idx);
      return {5'd0, idx} < 9'(SLOTS_PER_PATTERN);
   endfunction

   // pattern number 1..N to memory row
   function automatic logic [PAT_W-1:0] pat_row(logic [NUM_W-1:0] num);
      logic [NUM_W-1:0] row;
      row = num - NUM_W'(1);
      return PAT_W'(row);
   endfunction

   function automatic logic [SLOT_ADDR_W-1:0] slot_addr(logic [PAT_W-1:0]  row,
                                                        logic [SLOT_W-1:0] pos);
      return SLOT_ADDR_W'(row) * SLOT_ADDR_W'(SLOTS_PER_PATTERN) + SLOT_ADDR_W'(pos);
   endfunction

   // length byte, limited to the last slot
   function automatic logic [SLOT_W-1:0] clamp_len(logic [BYTE_W-1:0] len);
      if ({1'b0, len} > 9'(SLOTS_PER_PATTERN - 1)) begin
         return SLOT_W'(SLOTS_PER_PATTERN - 1);
      end
      return SLOT_W'(len);
   endfunction

endpackage

### hdl/lbps_ram.sv
module lbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/led_blink_pattern_sequencer.sv
// Two-LED blink pattern sequencer.
// req_ channel: one item per transfer. mode selects tick, start pattern,
//   write header or write slot byte. Every item gives exactly one rsp_
//   transfer with the LED levels, running pattern and save flag after it.
// csr_ channel: one-bit table_ready, always accepted; write only while idle.
// Throughput: one item per cycle while req_ready is high; each result is
//   registered in the output queue. Pattern headers and slot bytes live
//   in two RAMs with registered reads; the header and length of the
//   running and the saved pattern are cached in flops, and the single slot
//   read of a step (the next duration) is forwarded to the following item.
// Results go through a two-entry output queue: req_ready stays high while
//   a result waits and drops only when two results are pending on a stalled
//   receiver.
// Reset: idle, LEDs off, no saved pattern, table_ready cleared. The pattern
//   RAMs are not cleared; software loads them before setting table_ready.
module led_blink_pattern_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [lbps_pkg::NUM_W-1:0]    req_pattern_number,
   input  logic [lbps_pkg::IDX_W-1:0]    req_slot_index,
   input  logic [lbps_pkg::BYTE_W-1:0]   req_slot_value,
   input  logic [lbps_pkg::PRIO_W-1:0]   req_priority_level,
   input  logic [lbps_pkg::ROUND_W-1:0]  req_repeat_total,
   input  logic                          req_red_enable,
   input  logic                          req_green_enable,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_red_led,
   output logic                          rsp_green_led,
   output logic [lbps_pkg::NUM_W-1:0]    rsp_running_pattern,
   output logic                          rsp_pattern_saved,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_table_ready
);

   import lbps_pkg::*;

`include "led_blink_pattern_sequencer_defines.svh"

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic                table_ready_ff;
   logic [NUM_W-1:0]    active_ff,      active_in;
   logic [SLOT_W-1:0]   pos_ff,         pos_in;
   logic [ROUND_W-1:0]  round_ff,       round_in;
   logic [NUM_W-1:0]    saved_ff,       saved_in;
   logic [SLOT_W-1:0]   saved_pos_ff,   saved_pos_in;
   logic [ROUND_W-1:0]  saved_round_ff, saved_round_in;
   logic [CNT_W-1:0]    cnt_ff,         cnt_in;
   logic                red_ff,         red_in;
   logic                green_ff,       green_in;
   // cnt_pend: countdown is the slot RAM read data times ten
   logic                cnt_pend_ff,    cnt_pend_in;
   // ld_pend: header/length cache loads from RAM read data (after a start)
   logic                ld_pend_ff,     ld_pend_in;
   hdr_type             hdr_ff,         hdr_in;
   logic [SLOT_W-1:0]   len_ff,         len_in;
   hdr_type             saved_hdr_ff,   saved_hdr_in;
   logic [SLOT_W-1:0]   saved_len_ff,   saved_len_in;

   // output queue
   rsp_type             q0_ff, q0_in;
   rsp_type             q1_ff, q1_in;
   logic [1:0]          q_cnt_ff, q_cnt_in;

   // RAM ports
   logic                    hdr_wr_en, hdr_rd_en;
   logic [PAT_W-1:0]        hdr_wr_addr, hdr_rd_addr;
   logic [HDR_W-1:0]        hdr_rd_data;
   logic                    slot_wr_en, slot_rd_en;
   logic [SLOT_ADDR_W-1:0]  slot_wr_addr, slot_rd_addr;
   logic [BYTE_W-1:0]       slot_rd_data;

   // item decode
   logic                item;
   logic                pop;
   mode_type            mode;
   logic                nok;
   logic [PAT_W-1:0]    req_row;
   hdr_type             wr_hdr;

   // current values with pending RAM data folded in
   hdr_type             cur_hdr;
   logic [SLOT_W-1:0]   cur_len;
   logic [CNT_W-1:0]    cur_cnt;
   logic [SLOT_W-1:0]   pos_next;
   logic                locked;
   rsp_type             new_rsp;

   assign item      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign mode      = mode_type'(req_mode);
   assign nok       = num_ok(req_pattern_number);
   assign req_row   = pat_row(req_pattern_number);
   assign wr_hdr    = '{green:     req_green_enable,
                        red:       req_red_enable,
                        rep_total: req_repeat_total,
                        prio:      req_priority_level};

   assign cur_hdr   = ld_pend_ff ? hdr_type'(hdr_rd_data) : hdr_ff;
   assign cur_len   = ld_pend_ff ? clamp_len(slot_rd_data) : len_ff;
   assign cur_cnt   = cnt_pend_ff ? CNT_W'(slot_rd_data) * TICK_SCALE : cnt_ff;
   assign pos_next  = pos_ff + SLOT_W'(1);
   assign locked    = (active_ff != '0) && (cur_hdr.prio == PRIO_LOCK);

   // RAM write side comes straight from the item
   assign hdr_wr_en    = item && (mode == MODE_WR_HDR) && nok;
   assign hdr_wr_addr  = req_row;
   assign slot_wr_en   = item && (mode == MODE_WR_SLOT) && nok && idx_ok(req_slot_index);
   assign slot_wr_addr = slot_addr(req_row, SLOT_W'(req_slot_index));

   // ---------------------------------------------------------------------
   // Next state: pending RAM data resolves every cycle, then the item acts
   // ---------------------------------------------------------------------
   always_comb begin
      active_in      = active_ff;
      pos_in         = pos_ff;
      round_in       = round_ff;
      saved_in       = saved_ff;
      saved_pos_in   = saved_pos_ff;
      saved_round_in = saved_round_ff;
      cnt_in         = cur_cnt;
      red_in         = red_ff;
      green_in       = green_ff;
      hdr_in         = cur_hdr;
      len_in         = cur_len;
      saved_hdr_in   = saved_hdr_ff;
      saved_len_in   = saved_len_ff;
      cnt_pend_in    = 1'b0;
      ld_pend_in     = 1'b0;
      hdr_rd_en      = 1'b0;
      hdr_rd_addr    = req_row;
      slot_rd_en     = 1'b0;
      slot_rd_addr   = slot_addr(pat_row(active_ff), pos_next);

      if (item) begin
         unique case (mode)
            MODE_TICK: begin
               if (active_ff != '0) begin
                  if (cur_cnt != '0) begin
                     cnt_in = cur_cnt - CNT_W'(1);
                  end else if (pos_ff >= cur_len) begin
                     // end of round
                     priority if ((cur_hdr.rep_total == '0) ||
                                  (cur_hdr.rep_total > round_ff)) begin
                        round_in = round_ff + ROUND_W'(1);
                        pos_in   = '0;
                     end else if (saved_ff != '0) begin
                        active_in      = saved_ff;
                        pos_in         = saved_pos_ff;
                        round_in       = saved_round_ff;
                        hdr_in         = saved_hdr_ff;
                        len_in         = saved_len_ff;
                        saved_in       = '0;
                        saved_pos_in   = '0;
                        saved_round_in = '0;
                     end else begin
                        active_in = '0;
                     end
                  end else begin
                     // next slot: fetch its duration
                     pos_in      = pos_next;
                     slot_rd_en  = 1'b1;
                     cnt_pend_in = 1'b1;
                     if (pos_next[0]) begin
                        red_in   = red_ff   | cur_hdr.red;
                        green_in = green_ff | cur_hdr.green;
                     end else begin
                        red_in   = 1'b0;
                        green_in = 1'b0;
                     end
                  end
               end
            end
            MODE_START: begin
               if (table_ready_ff && nok && !locked) begin
                  if ((active_ff != '0) && (cur_hdr.prio == PRIO_SAVE)) begin
                     saved_in       = active_ff;
                     saved_pos_in   = pos_ff;
                     saved_round_in = round_ff;
                     saved_hdr_in   = cur_hdr;
                     saved_len_in   = cur_len;
                  end
                  active_in    = req_pattern_number;
                  pos_in       = '0;
                  round_in     = ROUND_W'(1);
                  red_in       = 1'b0;
                  green_in     = 1'b0;
                  cnt_in       = GAP_TICKS;
                  hdr_rd_en    = 1'b1;
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = slot_addr(req_row, '0);
                  ld_pend_in   = 1'b1;
               end
            end
            MODE_WR_HDR: begin
               // keep the caches coherent with the header RAM
               if (nok && (active_ff == req_pattern_number)) begin
                  hdr_in = wr_hdr;
               end
               if (nok && (saved_ff == req_pattern_number)) begin
                  saved_hdr_in = wr_hdr;
               end
            end
            MODE_WR_SLOT: begin
               if (slot_wr_en && (req_slot_index == '0)) begin
                  if (active_ff == req_pattern_number) begin
                     len_in = clamp_len(req_slot_value);
                  end
                  if (saved_ff == req_pattern_number) begin
                     saved_len_in = clamp_len(req_slot_value);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Output queue: two entries, head in q0
   // ---------------------------------------------------------------------
   assign new_rsp = '{red:     red_in,
                      green:   green_in,
                      running: active_in,
                      saved:   (saved_in != '0)};

   always_comb begin
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      q_cnt_in = q_cnt_ff;
      priority if (pop && item) begin
         if (q_cnt_ff == 2'd1) begin
            q0_in = new_rsp;
         end else begin
            q0_in = q1_ff;
            q1_in = new_rsp;
         end
      end else if (pop) begin
         q0_in    = q1_ff;
         q_cnt_in = q_cnt_ff - 2'd1;
      end else if (item) begin
         if (q_cnt_ff == 2'd0) begin
            q0_in = new_rsp;
         end else begin
            q1_in = new_rsp;
         end
         q_cnt_in = q_cnt_ff + 2'd1;
      end
   end

   assign req_ready           = (q_cnt_ff != 2'd2);
   assign rsp_valid           = (q_cnt_ff != 2'd0);
   assign rsp_red_led         = q0_ff.red;
   assign rsp_green_led       = q0_ff.green;
   assign rsp_running_pattern = q0_ff.running;
   assign rsp_pattern_saved   = q0_ff.saved;
   assign csr_ready           = 1'b1;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ready_ff <= 1'b0;
         active_ff      <= '0;
         pos_ff         <= '0;
         round_ff       <= '0;
         saved_ff       <= '0;
         saved_pos_ff   <= '0;
         saved_round_ff <= '0;
         cnt_ff         <= '0;
         red_ff         <= 1'b0;
         green_ff       <= 1'b0;
         cnt_pend_ff    <= 1'b0;
         ld_pend_ff     <= 1'b0;
         q_cnt_ff       <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            table_ready_ff <= csr_table_ready;
         end
         active_ff      <= active_in;
         pos_ff         <= pos_in;
         round_ff       <= round_in;
         saved_ff       <= saved_in;
         saved_pos_ff   <= saved_pos_in;
         saved_round_ff <= saved_round_in;
         cnt_ff         <= cnt_in;
         red_ff         <= red_in;
         green_ff       <= green_in;
         cnt_pend_ff    <= cnt_pend_in;
         ld_pend_ff     <= ld_pend_in;
         q_cnt_ff       <= q_cnt_in;
      end
   end

   // caches and queue payload
   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      len_ff       <= len_in;
      saved_hdr_ff <= saved_hdr_in;
      saved_len_ff <= saved_len_in;
      q0_ff        <= q0_in;
      q1_ff        <= q1_in;
   end

   // ---------------------------------------------------------------------
   // Pattern memories
   // ---------------------------------------------------------------------
   lbps_ram #(
      .WIDTH (HDR_W),
      .DEPTH (PATTERN_COUNT)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_wr_en),
      .wr_addr (hdr_wr_addr),
      .wr_data (HDR_W'(wr_hdr)),
      .rd_en   (hdr_rd_en),
      .rd_addr (hdr_rd_addr),
      .rd_data (hdr_rd_data)
   );

   lbps_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PATTERN_COUNT * SLOTS_PER_PATTERN)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (req_slot_value),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // slot read data is shared: a length load and a duration load never overlap
   `LBPS_ASSERT(a_pend_excl, !(ld_pend_ff && cnt_pend_ff), "slot read data claimed twice")
   // a saved pattern only exists under a running one
   `LBPS_ASSERT(a_saved_active, (saved_ff == '0) || (active_ff != '0), "saved without active")
   // a duration fetch belongs to a running pattern
   `LBPS_ASSERT(a_pend_active, !cnt_pend_ff || (active_ff != '0), "duration fetch while idle")
   // start is ignored until the table is marked ready
   `LBPS_ASSERT_NEXT(a_start_gate, item && (mode == MODE_START) && !table_ready_ff,
      $stable(active_ff) && $stable(saved_ff), "start taken without table_ready")

endmodule

### tb/sv/led_blink_pattern_sequencer_test.sv
module led_blink_pattern_sequencer_test;
   import lbps_pkg::*;

   // One request as the sender sees it; unused fields still carry values.
   typedef struct {
      mode_type            mode;
      logic [NUM_W-1:0]    num;
      logic [IDX_W-1:0]    idx;
      logic [BYTE_W-1:0]   value;
      logic [PRIO_W-1:0]   prio;
      logic [ROUND_W-1:0]  rep;
      logic                red;
      logic                green;
   } blink_cmd_type;

   // Directed script rows: a command (repeated count times), the table load,
   // or a table_ready write.
   typedef enum {ROW_CMD, ROW_LOAD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      blink_cmd_type  cmd;
      int unsigned    count;
      bit             csr_bit;
      bit             typed;
      rsp_type        want;
   } script_row_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT ports
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   logic                 req_valid          = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode           = 2'b00;
   logic [NUM_W-1:0]     req_pattern_number = '0;
   logic [IDX_W-1:0]     req_slot_index     = '0;
   logic [BYTE_W-1:0]    req_slot_value     = '0;
   logic [PRIO_W-1:0]    req_priority_level = '0;
   logic [ROUND_W-1:0]   req_repeat_total   = '0;
   logic                 req_red_enable     = 1'b0;
   logic                 req_green_enable   = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready          = 1'b0;
   logic                 rsp_red_led;
   logic                 rsp_green_led;
   logic [NUM_W-1:0]     rsp_running_pattern;
   logic                 rsp_pattern_saved;
   logic                 csr_valid          = 1'b0;
   logic                 csr_ready;
   logic                 csr_table_ready    = 1'b0;

   led_blink_pattern_sequencer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_pattern_number  (req_pattern_number),
      .req_slot_index      (req_slot_index),
      .req_slot_value      (req_slot_value),
      .req_priority_level  (req_priority_level),
      .req_repeat_total    (req_repeat_total),
      .req_red_enable      (req_red_enable),
      .req_green_enable    (req_green_enable),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_red_led         (rsp_red_led),
      .rsp_green_led       (rsp_green_led),
      .rsp_running_pattern (rsp_running_pattern),
      .rsp_pattern_saved   (rsp_pattern_saved),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_table_ready     (csr_table_ready)
   );

   // ---------------------------------------------------------------------
   // Sequencer mirror: own copy of table, run state and table_ready.
   // Starts at the post-reset state. Table entries are only read once
   // written (whole table is loaded before table_ready goes high).
   // ---------------------------------------------------------------------
   hdr_type              hdr_mirror  [PATTERN_COUNT];
   logic [BYTE_W-1:0]    slot_mirror [PATTERN_COUNT*SLOTS_PER_PATTERN];
   logic [NUM_W-1:0]     run_num    = '0;
   logic [IDX_W-1:0]     run_pos    = '0;
   logic [ROUND_W-1:0]   run_round  = '0;
   logic [NUM_W-1:0]     park_num   = '0;
   logic [IDX_W-1:0]     park_pos   = '0;
   logic [ROUND_W-1:0]   park_round = '0;
   logic [CNT_W-1:0]     tick_left  = '0;
   logic                 led_red    = 1'b0;
   logic                 led_green  = 1'b0;
   logic                 table_on   = 1'b0;

   rsp_type        pending_q [$];   // LED/pattern views still owed by the DUT
   script_row_type script [$];
   int unsigned    burst_left  = 0;
   int unsigned    error_count = 0;
   int unsigned    rsp_seen    = 0;

   function automatic bit known_pattern(logic [NUM_W-1:0] n);
      return (n != '0) && (int'(n) <= PATTERN_COUNT);
   endfunction

   function automatic int slot_ix(logic [NUM_W-1:0] n, logic [IDX_W-1:0] pos);
      return (int'(n) - 1) * SLOTS_PER_PATTERN + int'(pos);
   endfunction

   // Apply one request to the mirror and return the view after it.
   function automatic rsp_type blink_next(blink_cmd_type c);
      hdr_type           h;
      int                len;
      bit                blocked;
      rsp_type           view;
      case (c.mode)
         MODE_TICK: begin
            if (run_num != '0) begin
               if (tick_left != '0) begin
                  tick_left = tick_left - CNT_W'(1);
               end else begin
                  h   = hdr_mirror[run_num - NUM_W'(1)];
                  len = int'(slot_mirror[slot_ix(run_num, '0)]);
                  if (len > SLOTS_PER_PATTERN - 1) len = SLOTS_PER_PATTERN - 1;
                  if (int'(run_pos) >= len) begin
                     // end of round: repeat, resume the parked pattern, or go idle
                     if (h.rep_total == '0 || h.rep_total > run_round) begin
                        run_round = run_round + ROUND_W'(1);
                        run_pos   = '0;
                     end else if (park_num != '0) begin
                        run_num    = park_num;
                        run_pos    = park_pos;
                        run_round  = park_round;
                        park_num   = '0;
                        park_pos   = '0;
                        park_round = '0;
                     end else begin
                        run_num = '0;
                     end
                  end else begin
                     run_pos   = run_pos + IDX_W'(1);
                     tick_left = CNT_W'(int'(slot_mirror[slot_ix(run_num, run_pos)])
                                        * int'(TICK_SCALE));
                     if (run_pos[0]) begin
                        // odd slot: enabled LEDs on, others keep their level
                        if (h.red)   led_red   = 1'b1;
                        if (h.green) led_green = 1'b1;
                     end else begin
                        led_red   = 1'b0;
                        led_green = 1'b0;
                     end
                  end
               end
            end
         end
         MODE_START: begin
            if (table_on && known_pattern(c.num)) begin
               blocked = 1'b0;
               if (run_num != '0) begin
                  h = hdr_mirror[run_num - NUM_W'(1)];
                  if (h.prio == PRIO_LOCK) begin
                     blocked = 1'b1;
                  end else if (h.prio == PRIO_SAVE) begin
                     park_num   = run_num;
                     park_pos   = run_pos;
                     park_round = run_round;
                  end
               end
               if (!blocked) begin
                  run_num   = c.num;
                  run_pos   = '0;
                  run_round = ROUND_W'(1);
                  led_red   = 1'b0;
                  led_green = 1'b0;
                  tick_left = GAP_TICKS;
               end
            end
         end
         MODE_WR_HDR: begin
            if (known_pattern(c.num)) begin
               h.prio      = c.prio;
               h.rep_total = c.rep;
               h.red       = c.red;
               h.green     = c.green;
               hdr_mirror[c.num - NUM_W'(1)] = h;
            end
         end
         default: begin
            if (known_pattern(c.num)) slot_mirror[slot_ix(c.num, c.idx)] = c.value;
         end
      endcase
      view.red     = led_red;
      view.green   = led_green;
      view.running = run_num;
      view.saved   = (park_num != '0);
      return view;
   endfunction

   // ---------------------------------------------------------------------
   // Command builders and value shaping
   // ---------------------------------------------------------------------
   function automatic blink_cmd_type tick_cmd();
      blink_cmd_type c;
      c.mode = MODE_TICK; c.num = '0; c.idx = '0; c.value = '0;
      c.prio = '0; c.rep = '0; c.red = 1'b0; c.green = 1'b0;
      return c;
   endfunction

   function automatic blink_cmd_type start_cmd(logic [NUM_W-1:0] n);
      blink_cmd_type c;
      c      = tick_cmd();
      c.mode = MODE_START;
      c.num  = n;
      return c;
   endfunction

   function automatic blink_cmd_type hdr_cmd(logic [NUM_W-1:0] n, logic [PRIO_W-1:0] p,
                                             logic [ROUND_W-1:0] r, logic red,
                                             logic green);
      blink_cmd_type c;
      c       = tick_cmd();
      c.mode  = MODE_WR_HDR;
      c.num   = n;
      c.prio  = p;
      c.rep   = r;
      c.red   = red;
      c.green = green;
      return c;
   endfunction

   function automatic blink_cmd_type slot_cmd(logic [NUM_W-1:0] n, logic [IDX_W-1:0] i,
                                              logic [BYTE_W-1:0] v);
      blink_cmd_type c;
      c       = tick_cmd();
      c.mode  = MODE_WR_SLOT;
      c.num   = n;
      c.idx   = i;
      c.value = v;
      return c;
   endfunction

   function automatic rsp_type lamps_off(logic [NUM_W-1:0] n, logic saved);
      rsp_type v;
      v.red = 1'b0; v.green = 1'b0; v.running = n; v.saved = saved;
      return v;
   endfunction

   // mostly a few rounds, some endless, now and then anything
   function automatic logic [ROUND_W-1:0] pick_rounds();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r < 9) return ROUND_W'($urandom_range(1, 3));
      return ROUND_W'($urandom_range(0, 255));
   endfunction

   // short lengths and durations keep patterns cycling; long ones are rare
   function automatic logic [BYTE_W-1:0] pick_slot_byte(bit is_length);
      if ($urandom_range(0, 49) == 0) return BYTE_W'($urandom_range(0, 255));
      return BYTE_W'(is_length ? $urandom_range(0, 8) : $urandom_range(0, 3));
   endfunction

   function automatic logic [NUM_W-1:0] pick_pattern();
      if ($urandom_range(0, 9) == 0) return NUM_W'($urandom_range(0, 31));
      return NUM_W'($urandom_range(1, PATTERN_COUNT));
   endfunction

   // Tick-heavy mix so patterns actually run; all fields carry noise.
   function automatic blink_cmd_type random_cmd();
      blink_cmd_type c;
      int unsigned   pick;
      pick    = $urandom_range(0, 99);
      c.num   = NUM_W'($urandom_range(0, 31));
      c.idx   = IDX_W'($urandom_range(0, 15));
      c.value = BYTE_W'($urandom_range(0, 255));
      c.prio  = PRIO_W'($urandom_range(0, 3));
      c.rep   = ROUND_W'($urandom_range(0, 255));
      c.red   = 1'($urandom_range(0, 1));
      c.green = 1'($urandom_range(0, 1));
      if (pick < 72) begin
         c.mode = MODE_TICK;
      end else if (pick < 82) begin
         c.mode = MODE_START;
         c.num  = pick_pattern();
      end else if (pick < 89) begin
         c.mode = MODE_WR_HDR;
         c.num  = pick_pattern();
         c.rep  = pick_rounds();
      end else begin
         c.mode  = MODE_WR_SLOT;
         c.num   = pick_pattern();
         c.value = pick_slot_byte(c.idx == '0);
      end
      return c;
   endfunction

   function automatic void add_row(row_kind_type kind, blink_cmd_type c, int unsigned count,
                                   bit csr_bit, bit typed, rsp_type want);
      script_row_type r;
      r.kind = kind; r.cmd = c; r.count = count;
      r.csr_bit = csr_bit; r.typed = typed; r.want = want;
      script.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps between them. The
   // mirror is advanced at the transfer edge and its view queued, or the
   // row's typed-in expectation where it carries one.
   // ---------------------------------------------------------------------
   task automatic send_cmd(input blink_cmd_type c, input bit typed, input rsp_type want);
      int unsigned gap;
      rsp_type     view;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
      req_valid          <= 1'b1;
      req_mode           <= c.mode;
      req_pattern_number <= c.num;
      req_slot_index     <= c.idx;
      req_slot_value     <= c.value;
      req_priority_level <= c.prio;
      req_repeat_total   <= c.rep;
      req_red_enable     <= c.red;
      req_green_enable   <= c.green;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      view = blink_next(c);
      pending_q.push_back(typed ? want : view);
   endtask

   // table_ready only changes with the block idle: all results back first.
   task automatic set_table_ready(input bit on);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_table_ready <= on;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      table_on   = on;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: the stall style (none, light, heavy) is redrawn at random, periodically.
   // Each transfer is checked field by field against the oldest view.
   // ---------------------------------------------------------------------
   int unsigned    stall_cycle = 0;
   stall_mode_type stall_style = STALL_NONE;

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (pending_q.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $write("result %0d: none expected,", rsp_seen);
                  $display(" got red %0b green %0b pattern %0d saved %0b",
                           rsp_red_led, rsp_green_led, rsp_running_pattern,
                           rsp_pattern_saved);
               end
            end else begin
               want = pending_q.pop_front();
               if (rsp_red_led !== want.red || rsp_green_led !== want.green ||
                   rsp_running_pattern !== want.running ||
                   rsp_pattern_saved !== want.saved) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("result %0d: expected red %0b green %0b pattern %0d saved %0b,",
                            rsp_seen, want.red, want.green, want.running, want.saved);
                     $display(" got red %0b green %0b pattern %0d saved %0b",
                              rsp_red_led, rsp_green_led, rsp_running_pattern,
                              rsp_pattern_saved);
                  end
               end
            end
         end
         if (stall_cycle % 256 == 0) stall_style = stall_mode_type'($urandom_range(0, 2));
         stall_cycle++;
         case (stall_style)
            STALL_NONE:  rsp_ready <= 1'b1;
            STALL_LIGHT: rsp_ready <= ($urandom_range(0, 9) < 7);
            default:     rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stim
      int            i;
      int            k;
      int            p;
      int            phase;
      bit            on;
      blink_cmd_type c;

      // Before the table is ready: idle tick, ignored start, writes to
      // pattern numbers outside the table.
      add_row(ROW_CMD, tick_cmd(), 1, 1'b0, 1'b1, lamps_off(5'd0, 1'b0));
      add_row(ROW_CMD, start_cmd(5'd1), 1, 1'b0, 1'b1, lamps_off(5'd0, 1'b0));
      add_row(ROW_CMD, hdr_cmd(5'd0, 2'd1, 8'd1, 1'b1, 1'b1), 1, 1'b0, 1'b1,
              lamps_off(5'd0, 1'b0));
      add_row(ROW_CMD, slot_cmd(5'd31, 4'd15, 8'd255), 1, 1'b0, 1'b1,
              lamps_off(5'd0, 1'b0));
      add_row(ROW_CMD, hdr_cmd(5'd17, 2'd2, 8'd3, 1'b1, 1'b0), 1, 1'b0, 1'b1,
              lamps_off(5'd0, 1'b0));
      add_row(ROW_LOAD, tick_cmd(), 0, 1'b0, 1'b0, '0);
      add_row(ROW_CSR, tick_cmd(), 0, 1'b1, 1'b0, '0);
      // Top pattern: priority 3 (acts replaceable), max repeats, length
      // byte 255 clamped to the last slot.
      add_row(ROW_CMD, hdr_cmd(5'd16, 2'd3, 8'd255, 1'b1, 1'b1), 1, 1'b0, 1'b1,
              lamps_off(5'd0, 1'b0));
      add_row(ROW_CMD, slot_cmd(5'd16, 4'd0, 8'd255), 1, 1'b0, 1'b1,
              lamps_off(5'd0, 1'b0));
      add_row(ROW_CMD, start_cmd(5'd16), 1, 1'b0, 1'b1, lamps_off(5'd16, 1'b0));
      add_row(ROW_CMD, tick_cmd(), 6, 1'b0, 1'b0, '0);
      add_row(ROW_CMD, hdr_cmd(5'd2, 2'd1, 8'd1, 1'b1, 1'b0), 1, 1'b0, 1'b0, '0);
      // replaceable pattern gives way
      add_row(ROW_CMD, start_cmd(5'd2), 1, 1'b0, 1'b1, lamps_off(5'd2, 1'b0));
      add_row(ROW_CMD, hdr_cmd(5'd3, 2'd1, 8'd1, 1'b0, 1'b1), 1, 1'b0, 1'b1,
              lamps_off(5'd2, 1'b0));
      // priority 1 running: parked
      add_row(ROW_CMD, start_cmd(5'd3), 1, 1'b0, 1'b1, lamps_off(5'd3, 1'b1));
      add_row(ROW_CMD, hdr_cmd(5'd4, 2'd2, 8'd1, 1'b1, 1'b1), 1, 1'b0, 1'b1,
              lamps_off(5'd3, 1'b1));
      add_row(ROW_CMD, slot_cmd(5'd4, 4'd0, 8'd2), 1, 1'b0, 1'b1, lamps_off(5'd3, 1'b1));
      add_row(ROW_CMD, slot_cmd(5'd4, 4'd1, 8'd1), 1, 1'b0, 1'b1, lamps_off(5'd3, 1'b1));
      add_row(ROW_CMD, slot_cmd(5'd4, 4'd2, 8'd0), 1, 1'b0, 1'b1, lamps_off(5'd3, 1'b1));
      // second priority 1 override: the parked pattern is replaced
      add_row(ROW_CMD, start_cmd(5'd4), 1, 1'b0, 1'b1, lamps_off(5'd4, 1'b1));
      // locked pattern refuses a start; pattern 0 is ignored
      add_row(ROW_CMD, start_cmd(5'd5), 1, 1'b0, 1'b1, lamps_off(5'd4, 1'b1));
      add_row(ROW_CMD, start_cmd(5'd0), 1, 1'b0, 1'b1, lamps_off(5'd4, 1'b1));
      // run the locked pattern out: parked one resumes, save slot clears
      add_row(ROW_CMD, tick_cmd(), 20, 1'b0, 1'b0, '0);
      add_row(ROW_CSR, tick_cmd(), 0, 1'b0, 1'b0, '0);
      add_row(ROW_CMD, start_cmd(5'd1), 1, 1'b0, 1'b0, '0);
      add_row(ROW_CMD, tick_cmd(), 4, 1'b0, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < script.size(); i++) begin
         case (script[i].kind)
            ROW_CMD: begin
               repeat (script[i].count) send_cmd(script[i].cmd, script[i].typed, script[i].want);
            end
            ROW_LOAD: begin
               // full table, so no start can touch an unwritten entry
               for (p = 1; p <= PATTERN_COUNT; p++) begin
                  send_cmd(hdr_cmd(NUM_W'(p), PRIO_W'($urandom_range(0, 3)), pick_rounds(),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                           1'b0, '0);
                  for (k = 0; k < SLOTS_PER_PATTERN; k++)
                     send_cmd(slot_cmd(NUM_W'(p), IDX_W'(k), pick_slot_byte(k == 0)),
                              1'b0, '0);
               end
            end
            default: set_table_ready(script[i].csr_bit);
         endcase
      end

      // Random phases; table_ready forced on first, off once, mostly on.
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 0) on = 1'b1;
         else if (phase == 3) on = 1'b0;
         else on = ($urandom_range(0, 4) != 0);
         set_table_ready(on);
         for (i = 0; i < 250; i++) begin
            c = random_cmd();
            send_cmd(c, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      for (k = 0; k < 20000 && pending_q.size() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_q.size() == 0) begin
         $display("led_blink_pattern_sequencer_test: clean");
      end else begin
         $display("led_blink_pattern_sequencer_test: errors");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin : watchdog
      #(8 * 600000);
      $display("led_blink_pattern_sequencer_test: errors");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/lbps_pkg.sv
hdl/lbps_ram.sv
hdl/led_blink_pattern_sequencer.sv
tb/sv/led_blink_pattern_sequencer_test.sv
